/* sv/apbm_pkg.sv */
// ----------------------------------------------------------------------------
// apbm_pkg: shared types and constants of the pan / balance mixer
// Sizes, fixed-point constants, mode and register codes, and the queue entry
// that carries one classified frame from the front end to the mix engine.
// ----------------------------------------------------------------------------
package apbm_pkg;

   // channel and matrix sizes
   localparam int NUM_CH       = 6;
   localparam int MAX_CHANNELS = 6;
   localparam int CH_IDX_W     = $clog2(NUM_CH);

   // fixed-point formats
   localparam int SAMPLE_W = 24;
   localparam int FACTOR_W = 25;
   localparam int FRAC_W   = 24;
   localparam int WEIGHT_W = 32;
   localparam int CFG_W    = 26;
   localparam int WIDE_W   = WEIGHT_W + 2;
   localparam int PROD_W   = FACTOR_W + 1 + SAMPLE_W;
   localparam int ACC_W    = PROD_W + 1;
   localparam int RND_W    = ACC_W - FRAC_W;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE  = FACTOR_W'(1) << FRAC_W;
   localparam logic [FACTOR_W-1:0] FACTOR_ZERO = '0;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
   localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'((1 << (SAMPLE_W - 1)) - 1);
   localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(1 << (SAMPLE_W - 1));

   // off-diagonal factors, indexed by the output column they feed
   localparam int NUM_OFF   = 4;
   localparam int OFF_IDX_W = $clog2(NUM_OFF);

   // rear pair placement
   localparam logic [CH_IDX_W-1:0] CH_COUNT_5P1 = CH_IDX_W'(6);
   localparam logic [CH_IDX_W-1:0] REAR_5P1     = CH_IDX_W'(4);
   localparam logic [CH_IDX_W-1:0] REAR_DEFAULT = CH_IDX_W'(2);

   // mix engine: output columns per step and steps per frame
   localparam int LANES     = 2;
   localparam int NUM_STEPS = NUM_CH / LANES;
   localparam int STEP_W    = $clog2(NUM_STEPS);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

   // frame queue
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAN_MODE      = 3'd0,
      CSR_GANG_ENABLE   = 3'd1,
      CSR_CHANNEL_COUNT = 3'd2,
      CSR_START_WEIGHT  = 3'd3,
      CSR_WEIGHT_STEP   = 3'd4
   } csr_index_type;

   // pan / balance modes, unsigned 3-bit codes
   typedef enum logic [2:0] {
      MODE_PAN_0      = 3'b000,
      MODE_PAN_1      = 3'b001,
      MODE_PAN_2      = 3'b010,
      MODE_PAN_3      = 3'b011,
      MODE_RIGHT_FADE = 3'b100,
      MODE_LEFT_FADE  = 3'b101,
      MODE_REAR_BAL   = 3'b110,
      MODE_FRONT_BAL  = 3'b111
   } pan_mode_type;

   typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] frame_type;

   // one classified frame: samples plus the factors in force for it
   typedef struct packed {
      frame_type                           sample;
      logic [NUM_CH-1:0][FACTOR_W-1:0]     diag;
      logic [NUM_OFF-1:0][FACTOR_W-1:0]    offd;
      logic [CH_IDX_W-1:0]                 n;
   } q_entry_type;

   // queue status seen by the producer and the consumer
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

/* sv/apbm_front.sv */
// ----------------------------------------------------------------------------
// apbm_front: configuration registers, ramp weight and mixing matrix
// Applies the block restart and the selected mode to the matrix for every
// accepted frame and builds the queue entry holding the frame's factors.
// ----------------------------------------------------------------------------
module apbm_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [apbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [apbm_pkg::CFG_W-1:0]          csr_wdata,
   input  logic                                accept,
   input  apbm_pkg::frame_type                 sample,
   input  logic                                first_in_block,
   output apbm_pkg::q_entry_type               entry
);

   // configuration registers
   apbm_pkg::pan_mode_type                pan_mode_ff;
   logic                                  gang_enable_ff;
   logic [apbm_pkg::CH_IDX_W-1:0]         channel_count_ff;
   logic signed [apbm_pkg::CFG_W-1:0]     start_weight_ff;
   logic signed [apbm_pkg::CFG_W-1:0]     weight_step_ff;

   // block state
   logic signed [apbm_pkg::WEIGHT_W-1:0]  ramp_ff;
   logic signed [apbm_pkg::WEIGHT_W-1:0]  ramp_in;
   logic [apbm_pkg::FACTOR_W-1:0]         diag_ff [apbm_pkg::NUM_CH];
   logic [apbm_pkg::FACTOR_W-1:0]         diag_in [apbm_pkg::NUM_CH];
   logic [apbm_pkg::FACTOR_W-1:0]         offd_ff [apbm_pkg::NUM_OFF];
   logic [apbm_pkg::FACTOR_W-1:0]         offd_in [apbm_pkg::NUM_OFF];

   // weight derived values
   logic signed [apbm_pkg::WEIGHT_W-1:0]  w_cur;
   logic signed [apbm_pkg::WIDE_W-1:0]    omw;
   logic signed [apbm_pkg::WIDE_W-1:0]    opw;
   logic signed [apbm_pkg::WIDE_W-1:0]    one_wide;
   logic signed [apbm_pkg::WIDE_W-1:0]    two_wide;
   logic [apbm_pkg::FACTOR_W-1:0]         bal_first;
   logic [apbm_pkg::FACTOR_W-1:0]         bal_second;
   logic [apbm_pkg::FACTOR_W-1:0]         toward_first;
   logic [apbm_pkg::FACTOR_W-1:0]         toward_second;
   logic                                  w_neg;

   // mode classification
   logic [apbm_pkg::CH_IDX_W-1:0]         rear;
   logic [apbm_pkg::CH_IDX_W-1:0]         n_used;
   logic                                  pa0_en, pa1_en;
   logic [apbm_pkg::CH_IDX_W-1:0]         pa0_first, pa0_second;
   logic [apbm_pkg::CH_IDX_W-1:0]         pa1_first, pa1_second;
   logic                                  pan_en;
   logic                                  pan_odd;
   logic [apbm_pkg::CH_IDX_W-1:0]         pan_a;
   logic [apbm_pkg::CH_IDX_W-1:0]         pan_b;
   logic [apbm_pkg::NUM_CH-1:0]           is_first;
   logic [apbm_pkg::NUM_CH-1:0]           is_second;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pan_mode_ff      <= apbm_pkg::MODE_FRONT_BAL;
         gang_enable_ff   <= 1'b0;
         channel_count_ff <= apbm_pkg::CH_IDX_W'(2);
         start_weight_ff  <= '0;
         weight_step_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            apbm_pkg::CSR_PAN_MODE:
               pan_mode_ff <= apbm_pkg::pan_mode_type'(csr_wdata[2:0]);
            apbm_pkg::CSR_GANG_ENABLE:   gang_enable_ff   <= csr_wdata[0];
            apbm_pkg::CSR_CHANNEL_COUNT:
               channel_count_ff <= csr_wdata[apbm_pkg::CH_IDX_W-1:0];
            apbm_pkg::CSR_START_WEIGHT:  start_weight_ff  <= $signed(csr_wdata);
            apbm_pkg::CSR_WEIGHT_STEP:   weight_step_ff   <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // weight for this frame and the factors that follow from it
   always_comb begin
      w_cur    = first_in_block ? apbm_pkg::WEIGHT_W'(start_weight_ff) : ramp_ff;
      ramp_in  = w_cur + apbm_pkg::WEIGHT_W'(weight_step_ff);
      one_wide = $signed(apbm_pkg::WIDE_W'(apbm_pkg::FACTOR_ONE));
      two_wide = one_wide <<< 1;
      omw      = one_wide - apbm_pkg::WIDE_W'(w_cur);
      opw      = one_wide + apbm_pkg::WIDE_W'(w_cur);
      w_neg    = w_cur[apbm_pkg::WEIGHT_W-1];

      // balance and fade factors, clamped to [0, 1.0]
      if (omw < 0)              bal_first = apbm_pkg::FACTOR_ZERO;
      else if (omw > one_wide)  bal_first = apbm_pkg::FACTOR_ONE;
      else                      bal_first = omw[apbm_pkg::FACTOR_W-1:0];
      if (opw < 0)              bal_second = apbm_pkg::FACTOR_ZERO;
      else if (opw > one_wide)  bal_second = apbm_pkg::FACTOR_ONE;
      else                      bal_second = opw[apbm_pkg::FACTOR_W-1:0];

      // pan factors, clamped to [0, 2.0] then halved
      if (omw < 0)              toward_first = apbm_pkg::FACTOR_ZERO;
      else if (omw > two_wide)  toward_first = apbm_pkg::FACTOR_ONE;
      else                      toward_first = omw[apbm_pkg::FACTOR_W:1];
      if (opw < 0)              toward_second = apbm_pkg::FACTOR_ZERO;
      else if (opw > two_wide)  toward_second = apbm_pkg::FACTOR_ONE;
      else                      toward_second = opw[apbm_pkg::FACTOR_W:1];
   end

   // mode decode: which channel pairs the weight acts on
   always_comb begin
      rear = (channel_count_ff == apbm_pkg::CH_COUNT_5P1) ?
             apbm_pkg::REAR_5P1 : apbm_pkg::REAR_DEFAULT;
      n_used = (channel_count_ff > apbm_pkg::CH_IDX_W'(apbm_pkg::MAX_CHANNELS)) ?
               apbm_pkg::CH_IDX_W'(apbm_pkg::MAX_CHANNELS) : channel_count_ff;
      pa0_en     = 1'b0;
      pa1_en     = 1'b0;
      pa0_first  = '0;
      pa0_second = '0;
      pa1_first  = '0;
      pa1_second = '0;
      pan_en     = 1'b0;
      pan_odd    = pan_mode_ff[0];
      pan_a      = apbm_pkg::CH_IDX_W'({pan_mode_ff[1], 1'b0});
      pan_b      = pan_a + apbm_pkg::CH_IDX_W'(1);
      unique case (pan_mode_ff) inside
         apbm_pkg::MODE_FRONT_BAL: begin
            pa0_en     = 1'b1;
            pa0_first  = apbm_pkg::CH_IDX_W'(0);
            pa0_second = apbm_pkg::CH_IDX_W'(1);
            pa1_en     = gang_enable_ff;
            pa1_first  = rear;
            pa1_second = rear + apbm_pkg::CH_IDX_W'(1);
         end
         apbm_pkg::MODE_REAR_BAL: begin
            pa0_en     = 1'b1;
            pa0_first  = rear;
            pa0_second = rear + apbm_pkg::CH_IDX_W'(1);
         end
         apbm_pkg::MODE_LEFT_FADE: begin
            pa0_en     = 1'b1;
            pa0_first  = apbm_pkg::CH_IDX_W'(0);
            pa0_second = rear;
            pa1_en     = gang_enable_ff;
            pa1_first  = apbm_pkg::CH_IDX_W'(1);
            pa1_second = rear + apbm_pkg::CH_IDX_W'(1);
         end
         apbm_pkg::MODE_RIGHT_FADE: begin
            pa0_en     = 1'b1;
            pa0_first  = apbm_pkg::CH_IDX_W'(1);
            pa0_second = rear + apbm_pkg::CH_IDX_W'(1);
         end
         apbm_pkg::MODE_PAN_0, apbm_pkg::MODE_PAN_1,
         apbm_pkg::MODE_PAN_2, apbm_pkg::MODE_PAN_3: begin
            pan_en = 1'b1;
         end
         default: ;
      endcase
      for (int j = 0; j < apbm_pkg::NUM_CH; j++) begin
         is_first[j]  = (pa0_en && pa0_first  == apbm_pkg::CH_IDX_W'(j)) ||
                        (pa1_en && pa1_first  == apbm_pkg::CH_IDX_W'(j));
         is_second[j] = (pa0_en && pa0_second == apbm_pkg::CH_IDX_W'(j)) ||
                        (pa1_en && pa1_second == apbm_pkg::CH_IDX_W'(j));
      end
   end

   // matrix update: restart to identity, then the mode's rewrite
   always_comb begin
      for (int j = 0; j < apbm_pkg::NUM_CH; j++) begin
         diag_in[j] = first_in_block ? apbm_pkg::FACTOR_ONE : diag_ff[j];
         if (w_neg && is_second[j])
            diag_in[j] = bal_second;
         else if (!w_neg && is_first[j])
            diag_in[j] = bal_first;
         if (pan_en && pan_a == apbm_pkg::CH_IDX_W'(j))
            diag_in[j] = pan_odd ? apbm_pkg::FACTOR_ONE : toward_first;
         if (pan_en && pan_b == apbm_pkg::CH_IDX_W'(j))
            diag_in[j] = pan_odd ? toward_second : apbm_pkg::FACTOR_ONE;
      end
      for (int c = 0; c < apbm_pkg::NUM_OFF; c++) begin
         offd_in[c] = first_in_block ? apbm_pkg::FACTOR_ZERO : offd_ff[c];
         // odd pan feeds the lower column from the upper input
         if (pan_en && pan_odd && pan_a == apbm_pkg::CH_IDX_W'(c))
            offd_in[c] = toward_first;
         if (pan_en && !pan_odd && pan_b == apbm_pkg::CH_IDX_W'(c))
            offd_in[c] = toward_second;
      end
   end

   // queue entry; a cross term whose source channel is unused is dropped
   always_comb begin
      entry.sample = sample;
      entry.n      = n_used;
      for (int j = 0; j < apbm_pkg::NUM_CH; j++)
         entry.diag[j] = diag_in[j];
      for (int c = 0; c < apbm_pkg::NUM_OFF; c++)
         entry.offd[c] = ((apbm_pkg::CH_IDX_W'(c) ^ apbm_pkg::CH_IDX_W'(1)) < n_used) ?
                         offd_in[c] : apbm_pkg::FACTOR_ZERO;
   end

   // state advance on every accepted frame
   always_ff @(posedge clock) begin
      if (reset) begin
         ramp_ff <= '0;
         for (int j = 0; j < apbm_pkg::NUM_CH; j++)
            diag_ff[j] <= apbm_pkg::FACTOR_ONE;
         for (int c = 0; c < apbm_pkg::NUM_OFF; c++)
            offd_ff[c] <= apbm_pkg::FACTOR_ZERO;
      end else if (accept) begin
         ramp_ff <= ramp_in;
         diag_ff <= diag_in;
         offd_ff <= offd_in;
      end
   end

endmodule

/* sv/apbm_queue.sv */
// ----------------------------------------------------------------------------
// apbm_queue: frame queue between front end and mix engine
// Small first-in first-out store of classified frames; the head stays
// readable until the mix engine pops it.
// ----------------------------------------------------------------------------
module apbm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  apbm_pkg::q_entry_type  wr_entry,
   input  logic                   rd_en,
   output apbm_pkg::q_entry_type  rd_entry,
   output apbm_pkg::q_status_type status
);

   apbm_pkg::q_entry_type            store_ff [apbm_pkg::Q_DEPTH];
   logic [apbm_pkg::Q_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [apbm_pkg::Q_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [apbm_pkg::Q_CNT_W-1:0]     count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en)
         wr_ptr_in = (wr_ptr_ff == apbm_pkg::Q_PTR_W'(apbm_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + apbm_pkg::Q_PTR_W'(1);
      if (rd_en)
         rd_ptr_in = (rd_ptr_ff == apbm_pkg::Q_PTR_W'(apbm_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + apbm_pkg::Q_PTR_W'(1);
      if (wr_en && !rd_en)
         count_in = count_ff + apbm_pkg::Q_CNT_W'(1);
      else if (!wr_en && rd_en)
         count_in = count_ff - apbm_pkg::Q_CNT_W'(1);
      status.full  = (count_ff == apbm_pkg::Q_CNT_W'(apbm_pkg::Q_DEPTH));
      status.empty = (count_ff == '0);
      rd_entry     = store_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (wr_en)
         store_ff[wr_ptr_ff] <= wr_entry;
   end

endmodule

/* sv/apbm_mixer.sv */
// ----------------------------------------------------------------------------
// apbm_mixer: matrix mix engine with result register
// Works through the head frame two output columns per step on four shared
// multipliers, rounds and saturates, and holds the finished frame for pop.
// ----------------------------------------------------------------------------
module apbm_mixer (
   input  logic                   clock,
   input  logic                   reset,
   input  apbm_pkg::q_status_type q_status,
   input  apbm_pkg::q_entry_type  q_head,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output apbm_pkg::frame_type    rsp_mix
);

   // step sequencing
   logic [apbm_pkg::STEP_W-1:0]        step_ff, step_in;
   logic                               issue;
   logic                               stall;
   logic                               load_rsp;

   // multiply stage
   logic                               mul_vld_ff;
   logic                               mul_last_ff;
   logic [apbm_pkg::STEP_W-1:0]        mul_step_ff;
   logic [apbm_pkg::CH_IDX_W-1:0]      mul_n_ff;
   logic signed [apbm_pkg::PROD_W-1:0] prod_d_ff [apbm_pkg::LANES];
   logic signed [apbm_pkg::PROD_W-1:0] prod_o_ff [apbm_pkg::LANES];
   logic signed [apbm_pkg::PROD_W-1:0] prod_d_in [apbm_pkg::LANES];
   logic signed [apbm_pkg::PROD_W-1:0] prod_o_in [apbm_pkg::LANES];
   logic [apbm_pkg::CH_IDX_W-1:0]      col_mul   [apbm_pkg::LANES];
   logic [apbm_pkg::FACTOR_W-1:0]      off_fac   [apbm_pkg::LANES];

   // sum stage
   logic [apbm_pkg::CH_IDX_W-1:0]      col_sum   [apbm_pkg::LANES];
   logic signed [apbm_pkg::ACC_W-1:0]  acc       [apbm_pkg::LANES];
   logic signed [apbm_pkg::RND_W-1:0]  rnd       [apbm_pkg::LANES];
   logic [apbm_pkg::SAMPLE_W-1:0]      lane_val  [apbm_pkg::LANES];
   apbm_pkg::frame_type                asm_ff, asm_in;

   // result register
   logic                               rsp_vld_ff, rsp_vld_in;
   apbm_pkg::frame_type                rsp_data_ff;

   // issue control: the last step waits while an unread result holds the slot
   always_comb begin
      stall    = mul_vld_ff && mul_last_ff && rsp_vld_ff && !rsp_pop;
      issue    = !q_status.empty && !stall;
      q_pop    = issue && (step_ff == apbm_pkg::STEP_LAST);
      step_in  = step_ff;
      if (issue)
         step_in = (step_ff == apbm_pkg::STEP_LAST) ? '0 :
                   step_ff + apbm_pkg::STEP_W'(1);
      load_rsp   = mul_vld_ff && mul_last_ff && !stall;
      rsp_vld_in = load_rsp || (rsp_vld_ff && !rsp_pop);
   end

   // multiplier operands: own diagonal term and the partner cross term
   always_comb begin
      for (int l = 0; l < apbm_pkg::LANES; l++) begin
         col_mul[l] = apbm_pkg::CH_IDX_W'(int'(step_ff) * apbm_pkg::LANES + l);
         off_fac[l] = (col_mul[l] < apbm_pkg::CH_IDX_W'(apbm_pkg::NUM_OFF)) ?
                      q_head.offd[col_mul[l][apbm_pkg::OFF_IDX_W-1:0]] :
                      apbm_pkg::FACTOR_ZERO;
         prod_d_in[l] = $signed({1'b0, q_head.diag[col_mul[l]]}) *
                        $signed(q_head.sample[col_mul[l]]);
         prod_o_in[l] = $signed({1'b0, off_fac[l]}) *
                        $signed(q_head.sample[col_mul[l] ^ apbm_pkg::CH_IDX_W'(1)]);
      end
   end

   // add, round half up, saturate; unused columns give zero
   always_comb begin
      asm_in = asm_ff;
      for (int l = 0; l < apbm_pkg::LANES; l++) begin
         col_sum[l] = apbm_pkg::CH_IDX_W'(int'(mul_step_ff) * apbm_pkg::LANES + l);
         acc[l] = apbm_pkg::ACC_W'(prod_d_ff[l]) + apbm_pkg::ACC_W'(prod_o_ff[l]) +
                  apbm_pkg::ROUND_HALF;
         rnd[l] = apbm_pkg::RND_W'(acc[l] >>> apbm_pkg::FRAC_W);
         if (col_sum[l] >= mul_n_ff)
            lane_val[l] = '0;
         else if (rnd[l] > apbm_pkg::SAT_MAX)
            lane_val[l] = apbm_pkg::SAT_MAX[apbm_pkg::SAMPLE_W-1:0];
         else if (rnd[l] < apbm_pkg::SAT_MIN)
            lane_val[l] = apbm_pkg::SAT_MIN[apbm_pkg::SAMPLE_W-1:0];
         else
            lane_val[l] = rnd[l][apbm_pkg::SAMPLE_W-1:0];
         if (mul_vld_ff && !stall)
            asm_in[col_sum[l]] = lane_val[l];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= '0;
         mul_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         rsp_vld_ff <= rsp_vld_in;
         if (!stall)
            mul_vld_ff <= issue;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (issue) begin
         mul_step_ff <= step_ff;
         mul_last_ff <= (step_ff == apbm_pkg::STEP_LAST);
         mul_n_ff    <= q_head.n;
         prod_d_ff   <= prod_d_in;
         prod_o_ff   <= prod_o_in;
      end
      asm_ff <= asm_in;
      if (load_rsp)
         rsp_data_ff <= asm_in;
   end

   assign rsp_empty = !rsp_vld_ff;
   assign rsp_mix   = rsp_data_ff;

`ifndef SYNTHESIS
   // step counter stays within one frame's steps
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= apbm_pkg::STEP_LAST)
      else $error("mix step counter out of range");

   // queue head leaves only on the last step of its frame
   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (step_ff == apbm_pkg::STEP_LAST) && !q_status.empty)
      else $error("frame popped before its last step");

   // a finished frame always lands in the result register
   a_last_loads: assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && mul_last_ff && !stall) |=> rsp_vld_ff)
      else $error("finished frame not presented");

   // a stalled last step keeps its products
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> mul_vld_ff && mul_last_ff && $stable(mul_n_ff))
      else $error("stalled step lost its state");
`endif

endmodule

/* sv/audio_pan_balance_mixer.sv */
// ----------------------------------------------------------------------------
// audio_pan_balance_mixer: pan / balance matrix mixer, up to six channels
// Top level: front end with matrix state, frame queue and mix engine.
// ----------------------------------------------------------------------------
// The front end takes one sample frame per clock while the two-entry frame
// queue has room, applies block restart and the pan or balance mode to the
// matrix, and queues the frame with its factors. The mix engine then works
// through the head frame two output channels per cycle, unless an unread
// result stalls its last step, on four shared 25x24 multipliers; each step's
// products are registered, then rounded and assembled. A finished frame is
// held in a result register while the next one is mixed. Configuration is
// to be written by the user only while idle; the block does not enforce it.
module audio_pan_balance_mixer (
   input  logic                                  clock,
   input  logic                                  reset,
   // input transactions
   input  logic                                  push,
   output logic                                  full,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_0,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_1,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_2,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_3,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_4,
   input  logic signed [apbm_pkg::SAMPLE_W-1:0]  req_sample_in_5,
   input  logic                                  req_first_in_block,
   // result transactions
   output logic                                  empty,
   input  logic                                  pop,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_0,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_1,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_2,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_3,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_4,
   output logic signed [apbm_pkg::SAMPLE_W-1:0]  rsp_mix_out_5,
   // configuration writes
   input  logic                                  csr_wr_en,
   input  logic [apbm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [apbm_pkg::CFG_W-1:0]            csr_wdata
);

   logic                   accept;
   logic                   q_pop;
   apbm_pkg::frame_type    req_frame;
   apbm_pkg::frame_type    rsp_frame;
   apbm_pkg::q_entry_type  q_wr_entry;
   apbm_pkg::q_entry_type  q_head;
   apbm_pkg::q_status_type q_status;

   // input transaction and sample bundle
   assign full   = q_status.full;
   assign accept = push && !q_status.full;
   assign req_frame = {req_sample_in_5, req_sample_in_4, req_sample_in_3,
                       req_sample_in_2, req_sample_in_1, req_sample_in_0};

   apbm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .accept         (accept),
      .sample         (req_frame),
      .first_in_block (req_first_in_block),
      .entry          (q_wr_entry)
   );

   apbm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_entry (q_wr_entry),
      .rd_en    (q_pop),
      .rd_entry (q_head),
      .status   (q_status)
   );

   apbm_mixer u_mixer (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_mix   (rsp_frame)
   );

   // result fields
   assign rsp_mix_out_0 = $signed(rsp_frame[0]);
   assign rsp_mix_out_1 = $signed(rsp_frame[1]);
   assign rsp_mix_out_2 = $signed(rsp_frame[2]);
   assign rsp_mix_out_3 = $signed(rsp_frame[3]);
   assign rsp_mix_out_4 = $signed(rsp_frame[4]);
   assign rsp_mix_out_5 = $signed(rsp_frame[5]);

endmodule
